### src/sfrr_pkg.sv
// ============================================================================
// Servo frame receiver package
// Shared widths, codes, reset values and the reciprocal table used to scale
// angles onto pulse ranges.
// ============================================================================
`timescale 1ns / 1ps

package sfrr_pkg;

    localparam int N_SERVO     = 4;
    localparam int N_ANGLE     = 4;
    localparam int N_CFG       = 2 * N_SERVO;
    localparam int PULSE_W     = 12;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int RAMP_STEP   = 10;
    localparam int ANGLE_LIMIT = 180;

    // Angles are scaled by a table of ceil(a * 2^RECIP_SHIFT / 180). The shift
    // is large enough that the product, shifted down, is the exact quotient.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PRODUCT_W   = RECIP_W + PULSE_W;

    typedef logic [PULSE_W-1:0]   pulse_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [RECIP_W-1:0]   recip_t;
    typedef logic [1:0]           angle_sel_t;

    localparam byte_t START_BYTE  = 8'hAA;
    localparam byte_t END_BYTE    = 8'h55;
    localparam byte_t CHECK_MASK  = 8'hFF;
    localparam byte_t ANGLE_MAX   = byte_t'(ANGLE_LIMIT);
    localparam byte_t ANGLE_RESET = 8'd90;

    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_LINK   = 2'd2,
        ACT_RESYNC = 2'd3
    } action_t;

    typedef enum logic [7:0] {
        PH_WAIT   = 8'b0000_0001,
        PH_ANGLE0 = 8'b0000_0010,
        PH_ANGLE1 = 8'b0000_0100,
        PH_ANGLE2 = 8'b0000_1000,
        PH_ANGLE3 = 8'b0001_0000,
        PH_STATUS = 8'b0010_0000,
        PH_CHECK  = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } phase_t;

    typedef byte_t [N_ANGLE-1:0] angles_t;

    typedef struct packed {
        logic link_up;
        logic link_request_pending;
        logic frame_accepted;
        logic checksum_failed;
    } parse_flags_t;

    // Pulses are held in servo order: wrist, gripper, elbow, shoulder.
    typedef struct packed {
        parse_flags_t                flags;
        pulse_t [N_SERVO-1:0]        pulse;
    } result_t;

    // Minimum and maximum for each servo, minimum first.
    localparam pulse_t CFG_RESET [N_CFG] = '{
        12'd900, 12'd2430, 12'd500, 12'd1200,
        12'd800, 12'd2480, 12'd700, 12'd2200
    };

    localparam pulse_t RESET_PULSE [N_SERVO] = '{12'd530, 12'd620, 12'd530, 12'd540};

    // Frame angle slot that drives each servo.
    localparam angle_sel_t ANGLE_SEL [N_SERVO] = '{2'd2, 2'd3, 2'd0, 2'd1};

    typedef recip_t recip_tab_t [0:ANGLE_LIMIT];

    function automatic recip_tab_t build_recip_table();
        recip_tab_t tab;
        for (int i = 0; i <= ANGLE_LIMIT; i++)
        begin
            tab[i] = recip_t'(((i << RECIP_SHIFT) + ANGLE_LIMIT - 1) / ANGLE_LIMIT);
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TABLE = build_recip_table();

endpackage

### src/sfrr_if.sv
// ============================================================================
// Servo frame receiver channels
// Request channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface sfrr_in_if;
    import sfrr_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    byte_t       rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sfrr_out_if;
    import sfrr_pkg::*;

    logic   valid;
    logic   ready;
    logic   link_up;
    logic   link_request_pending;
    logic   frame_accepted;
    logic   checksum_failed;
    pulse_t wrist_pulse;
    pulse_t gripper_pulse;
    pulse_t elbow_pulse;
    pulse_t shoulder_pulse;

    modport source (
        output valid, output link_up, output link_request_pending,
        output frame_accepted, output checksum_failed, output wrist_pulse,
        output gripper_pulse, output elbow_pulse, output shoulder_pulse,
        input ready
    );
    modport sink (
        input valid, input link_up, input link_request_pending,
        input frame_accepted, input checksum_failed, input wrist_pulse,
        input gripper_pulse, input elbow_pulse, input shoulder_pulse,
        output ready
    );
endinterface

### src/sfrr_parser.sv
// ============================================================================
// Frame parser and link handshake
// Walks the frame one byte at a time, checks the check byte and settles the
// link state on a valid end byte.
// ============================================================================
`timescale 1ns / 1ps

module sfrr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [1:0]            action,
    input  sfrr_pkg::byte_t       rx_byte,
    output sfrr_pkg::parse_flags_t flags,
    output logic                  aim,
    output sfrr_pkg::angles_t     angles
);
    import sfrr_pkg::*;

    phase_t  phase_reg,     phase_next;
    angles_t angles_reg,    angles_next;
    byte_t   status_reg,    status_next;
    logic    linked_reg,    linked_next;
    logic    pending_reg,   pending_next;
    logic    requested_reg, requested_next;
    logic    accepted;
    logic    bad_check;
    logic    aim_next;
    byte_t   check_sum;

    assign check_sum = angles_reg[0] ^ angles_reg[1] ^ angles_reg[2] ^ angles_reg[3]
                     ^ status_reg ^ CHECK_MASK;

    always_comb
    begin
        phase_next     = phase_reg;
        angles_next    = angles_reg;
        status_next    = status_reg;
        linked_next    = linked_reg;
        pending_next   = pending_reg;
        requested_next = requested_reg;
        accepted       = 1'b0;
        bad_check      = 1'b0;
        aim_next       = 1'b0;

        if (step)
        begin
            unique case (action_t'(action))
                ACT_BYTE:
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (rx_byte == START_BYTE)
                            begin
                                phase_next = PH_ANGLE0;
                            end
                        end
                        PH_ANGLE0:
                        begin
                            angles_next[0] = rx_byte;
                            phase_next     = PH_ANGLE1;
                        end
                        PH_ANGLE1:
                        begin
                            angles_next[1] = rx_byte;
                            phase_next     = PH_ANGLE2;
                        end
                        PH_ANGLE2:
                        begin
                            angles_next[2] = rx_byte;
                            phase_next     = PH_ANGLE3;
                        end
                        PH_ANGLE3:
                        begin
                            angles_next[3] = rx_byte;
                            phase_next     = PH_STATUS;
                        end
                        PH_STATUS:
                        begin
                            status_next = rx_byte;
                            phase_next  = PH_CHECK;
                        end
                        PH_CHECK:
                        begin
                            if (rx_byte == check_sum)
                            begin
                                phase_next = PH_END;
                            end
                            else
                            begin
                                bad_check  = 1'b1;
                                phase_next = PH_WAIT;
                            end
                        end
                        PH_END:
                        begin
                            if (rx_byte == END_BYTE)
                            begin
                                accepted = 1'b1;
                                // A pending request is confirmed when the
                                // partner echoes the requested state.
                                if (pending_reg && status_reg == {7'b0, requested_reg})
                                begin
                                    pending_next = 1'b0;
                                    linked_next  = requested_reg;
                                end
                                // A zero status always drops an established link.
                                if (status_reg == '0 && linked_next)
                                begin
                                    linked_next  = 1'b0;
                                    pending_next = 1'b0;
                                end
                                aim_next = linked_next;
                            end
                            phase_next = PH_WAIT;
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
                ACT_TICK:
                begin
                end
                ACT_LINK:
                begin
                    pending_next   = 1'b1;
                    requested_next = ~linked_reg;
                end
                ACT_RESYNC:
                begin
                    phase_next = PH_WAIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            angles_reg    <= {N_ANGLE{ANGLE_RESET}};
            status_reg    <= '0;
            linked_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            requested_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            angles_reg    <= angles_next;
            status_reg    <= status_next;
            linked_reg    <= linked_next;
            pending_reg   <= pending_next;
            requested_reg <= requested_next;
        end
    end

    assign flags.link_up              = linked_next;
    assign flags.link_request_pending = pending_next;
    assign flags.frame_accepted       = accepted;
    assign flags.checksum_failed      = bad_check;
    assign aim                        = aim_next;
    assign angles                     = angles_reg;

endmodule

### src/sfrr_servo.sv
// ============================================================================
// Servo target scaling and ramp
// Maps a frame angle onto the servo's pulse range and steps the current
// pulse towards its target on a ramp tick.
// ============================================================================
`timescale 1ns / 1ps

module sfrr_servo (
    input  sfrr_pkg::pulse_t range_lo,
    input  sfrr_pkg::pulse_t range_hi,
    input  sfrr_pkg::byte_t  angle,
    input  sfrr_pkg::pulse_t current,
    input  sfrr_pkg::pulse_t target,
    input  logic             tick,
    input  logic             aim,
    output sfrr_pkg::pulse_t current_next,
    output sfrr_pkg::pulse_t target_next
);
    import sfrr_pkg::*;

    byte_t                angle_sat;
    pulse_t               span;
    recip_t               recip;
    logic [PRODUCT_W-1:0] product;
    pulse_t               scaled;
    logic [PULSE_W:0]     aim_sum;
    pulse_t               aim_pulse;
    pulse_t               slew_step;
    pulse_t               ramp_pulse;

    assign angle_sat = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
    assign span      = (range_hi >= range_lo) ? (range_hi - range_lo) : '0;
    assign recip     = RECIP_TABLE[angle_sat];

    // The quotient angle * span / 180 never exceeds span, so it fits the pulse width.
    assign product   = PRODUCT_W'(recip) * PRODUCT_W'(span);
    assign scaled    = product[RECIP_SHIFT +: PULSE_W];
    assign aim_sum   = {1'b0, range_lo} + {1'b0, scaled};
    assign aim_pulse = aim_sum[PULSE_W-1:0];

    assign slew_step = PULSE_W'(RAMP_STEP);

    always_comb
    begin
        ramp_pulse = current;
        if (target > current)
        begin
            if ((target - current) <= slew_step)
            begin
                ramp_pulse = target;
            end
            else
            begin
                ramp_pulse = current + slew_step;
            end
        end
        else if (target < current)
        begin
            if ((current - target) <= slew_step)
            begin
                ramp_pulse = target;
            end
            else
            begin
                ramp_pulse = current - slew_step;
            end
        end
    end

    assign current_next = tick ? ramp_pulse : current;
    assign target_next  = aim  ? aim_pulse  : target;

endmodule

### src/sfrr_skid.sv
// ============================================================================
// Result output buffer
// Output register with one skid entry, so the request side can hand over one
// further result while the result side stalls.
// ============================================================================
`timescale 1ns / 1ps

module sfrr_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfrr_pkg::result_t data,
    output logic              space,
    sfrr_out_if.source        res
);
    import sfrr_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = res.ready || !out_valid_reg;
    assign space    = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No push can arrive while the skid entry is occupied.
            if (res.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (out_free)
        begin
            if (push)
            begin
                out_data_reg <= data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= data;
        end
    end

    assign res.valid                = out_valid_reg;
    assign res.link_up              = out_data_reg.flags.link_up;
    assign res.link_request_pending = out_data_reg.flags.link_request_pending;
    assign res.frame_accepted       = out_data_reg.flags.frame_accepted;
    assign res.checksum_failed      = out_data_reg.flags.checksum_failed;
    assign res.wrist_pulse          = out_data_reg.pulse[0];
    assign res.gripper_pulse        = out_data_reg.pulse[1];
    assign res.elbow_pulse          = out_data_reg.pulse[2];
    assign res.shoulder_pulse       = out_data_reg.pulse[3];

endmodule

### src/servo_frame_receiver_with_ramp_top.sv
// ============================================================================
// Servo frame receiver with ramped pulse outputs
// Parses framed servo commands, handles the link handshake and slews four
// servo pulse widths towards their targets.
// ============================================================================
// Usage.
// Requests arrive on the cmd channel: a received byte, a ramp tick, a link
// toggle request or a line error resync. Every accepted request produces
// exactly one result on the res channel, carrying the link flags, the frame
// and check flags for that byte, and the four current pulse widths after the
// request has been applied.
// The request is processed in the cycle it is accepted; its result goes to the
// output register, or to the skid entry while the result side stalls. One
// request can be accepted in every cycle while the skid entry is free. The
// critical path is the angle scaling on a frame's end byte: a reciprocal table
// look-up and one 21 by 12 bit multiply per servo, all four in parallel.
// Pulse ranges are set through the write port (cfg_we, cfg_index, cfg_wdata)
// with minimum and maximum per servo; writes take effect at once and should
// be made only while no request is in flight.
// Reset returns the parser to waiting for a start byte, drops the link, sets
// every angle to 90 and restores the reset pulse widths and ranges.
// When the result side stalls, one further result is held in a skid entry;
// after that cmd.ready falls until the result side takes a result.
// ============================================================================
`timescale 1ns / 1ps

module servo_frame_receiver_with_ramp_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  sfrr_pkg::cfg_idx_t cfg_index,
    input  sfrr_pkg::pulse_t   cfg_wdata,
    sfrr_in_if.sink            cmd,
    sfrr_out_if.source         res
);
    import sfrr_pkg::*;

    pulse_t       cfg_reg     [N_CFG];
    pulse_t       current_reg [N_SERVO];
    pulse_t       target_reg  [N_SERVO];
    pulse_t       current_next[N_SERVO];
    pulse_t       target_next [N_SERVO];
    logic         in_accept;
    logic         tick;
    logic         aim;
    logic         space;
    parse_flags_t pflags;
    angles_t      angles;
    result_t      result;

    assign cmd.ready = space;
    assign in_accept = cmd.valid && cmd.ready;
    assign tick      = in_accept && (cmd.action == ACT_TICK);

    // Pulse range registers, minimum at even index and maximum at odd index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    sfrr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_accept),
        .action  (cmd.action),
        .rx_byte (cmd.rx_byte),
        .flags   (pflags),
        .aim     (aim),
        .angles  (angles)
    );

    for (genvar k = 0; k < N_SERVO; k++)
    begin : g_servo
        sfrr_servo u_servo (
            .range_lo     (cfg_reg[2 * k]),
            .range_hi     (cfg_reg[2 * k + 1]),
            .angle        (angles[ANGLE_SEL[k]]),
            .current      (current_reg[k]),
            .target       (target_reg[k]),
            .tick         (tick),
            .aim          (aim),
            .current_next (current_next[k]),
            .target_next  (target_next[k])
        );

        assign result.pulse[k] = current_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_SERVO; i++)
            begin
                current_reg[i] <= RESET_PULSE[i];
                target_reg[i]  <= RESET_PULSE[i];
            end
        end
        else
        begin
            for (int i = 0; i < N_SERVO; i++)
            begin
                current_reg[i] <= current_next[i];
                target_reg[i]  <= target_next[i];
            end
        end
    end

    assign result.flags = pflags;

    sfrr_skid u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_accept),
        .data  (result),
        .space (space),
        .res   (res)
    );

    // The request side only stalls while a result is waiting at the output.
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> res.valid)
        else $error("request side stalled with no result waiting");

    // A single byte cannot both fail the check and complete a frame.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !(pflags.frame_accepted && pflags.checksum_failed))
        else $error("frame accepted and check failed on the same byte");

    // Targets are only set from a frame that leaves the link up.
    a_aim_when_linked: assert property (@(posedge clk) disable iff (!rst_n)
        aim |-> (pflags.link_up && pflags.frame_accepted))
        else $error("servo targets set without an established link");

    // Current pulses move only on a ramp tick.
    a_pulse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> ($stable(current_reg[0]) && $stable(current_reg[1])
                   && $stable(current_reg[2]) && $stable(current_reg[3])))
        else $error("current pulse changed without a ramp tick");

endmodule
